[rtl/qvr_pkg.sv]
package qvr_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 17;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 35;
    localparam int NUM_W     = 52;
    localparam int DEN_W     = 33;
    localparam int DVS_W     = DEN_W + 1;
    localparam int Q_W       = 17;
    localparam int OUT_LIMIT = 56756;
    localparam int AXES      = 3;

    typedef logic signed [IN_W-1:0]   in_t;
    typedef logic signed [OUT_W-1:0]  out_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [NUM_W-1:0]  num_t;
    typedef logic [NUM_W-1:0]         mag_t;
    typedef logic [DEN_W-1:0]         den_t;
    typedef logic [DVS_W-1:0]         dvs_t;
    typedef logic [Q_W-1:0]           quo_t;
    typedef logic [AXES-1:0][NUM_W-1:0] mag3_t;
    typedef logic [AXES-1:0][Q_W-1:0]   quo3_t;

    typedef struct packed {
        logic            valid;
        logic            zero;
        logic [AXES-1:0] neg;
    } div_ctl_t;

endpackage

[rtl/qvr_front.sv]
module qvr_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  qvr_pkg::in_t       vec_x,
    input  qvr_pkg::in_t       vec_y,
    input  qvr_pkg::in_t       vec_z,
    input  qvr_pkg::in_t       quat_w,
    input  qvr_pkg::in_t       quat_bx,
    input  qvr_pkg::in_t       quat_by,
    input  qvr_pkg::in_t       quat_bz,
    output qvr_pkg::div_ctl_t  ctl,
    output qvr_pkg::mag3_t     dividend,
    output qvr_pkg::dvs_t      divisor
);
    import qvr_pkg::*;

    // stage 1: all 16x16 products
    logic  v1_reg, z1_reg;
    in_t   vv1_reg [AXES];
    in_t   bb1_reg [AXES];
    in_t   w1_reg;
    prod_t ww1_reg;
    prod_t sq1_reg [AXES];
    prod_t dt1_reg [AXES];
    prod_t cp1_reg [AXES];   // first cross-product term
    prod_t cm1_reg [AXES];   // subtracted cross-product term

    // stage 2: sums
    logic  v2_reg, z2_reg;
    in_t   vv2_reg [AXES];
    in_t   bb2_reg [AXES];
    sum_t  w2x2_reg;
    sum_t  s2_reg, dot2_reg;
    sum_t  cr2_reg [AXES];
    den_t  den2_reg;

    // stage 3: wide products
    logic  v3_reg, z3_reg;
    den_t  den3_reg;
    num_t  ps3_reg [AXES];
    num_t  pd3_reg [AXES];
    num_t  pc3_reg [AXES];

    // stage 4: numerators
    logic  v4_reg, z4_reg;
    den_t  den4_reg;
    num_t  n4_reg [AXES];

    // stage 5: magnitude and rounding offset
    div_ctl_t ctl_reg;
    mag3_t    dd_reg;
    dvs_t     dvs_reg;

    sum_t b2_c;
    in_t  vin [AXES];
    in_t  bin [AXES];

    assign vin = '{vec_x, vec_y, vec_z};
    assign bin = '{quat_bx, quat_by, quat_bz};
    assign b2_c = sum_t'(sq1_reg[0]) + sum_t'(sq1_reg[1]) + sum_t'(sq1_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            ctl_reg.valid <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z1_reg  <= (quat_w == '0) && (quat_bx == '0) && (quat_by == '0) && (quat_bz == '0);
            w1_reg  <= quat_w;
            ww1_reg <= prod_t'(quat_w) * prod_t'(quat_w);
            for (int a = 0; a < AXES; a++) begin
                vv1_reg[a] <= vin[a];
                bb1_reg[a] <= bin[a];
                sq1_reg[a] <= prod_t'(bin[a]) * prod_t'(bin[a]);
                dt1_reg[a] <= prod_t'(vin[a]) * prod_t'(bin[a]);
                // (b x v)[a] = b[a+1]*v[a+2] - b[a+2]*v[a+1]
                cp1_reg[a] <= prod_t'(bin[(a+1)%AXES]) * prod_t'(vin[(a+2)%AXES]);
                cm1_reg[a] <= prod_t'(bin[(a+2)%AXES]) * prod_t'(vin[(a+1)%AXES]);
            end

            z2_reg   <= z1_reg;
            w2x2_reg <= sum_t'(w1_reg) <<< 1;
            s2_reg   <= sum_t'(ww1_reg) - b2_c;
            den2_reg <= den_t'(sum_t'(ww1_reg) + b2_c);
            dot2_reg <= (sum_t'(dt1_reg[0]) + sum_t'(dt1_reg[1]) + sum_t'(dt1_reg[2])) <<< 1;
            for (int a = 0; a < AXES; a++) begin
                vv2_reg[a] <= vv1_reg[a];
                bb2_reg[a] <= bb1_reg[a];
                cr2_reg[a] <= sum_t'(cp1_reg[a]) - sum_t'(cm1_reg[a]);
            end

            z3_reg   <= z2_reg;
            den3_reg <= den2_reg;
            for (int a = 0; a < AXES; a++) begin
                ps3_reg[a] <= num_t'(vv2_reg[a]) * num_t'(s2_reg);
                pd3_reg[a] <= num_t'(bb2_reg[a]) * num_t'(dot2_reg);
                pc3_reg[a] <= num_t'(w2x2_reg) * num_t'(cr2_reg[a]);
            end

            z4_reg   <= z3_reg;
            den4_reg <= den3_reg;
            for (int a = 0; a < AXES; a++) begin
                n4_reg[a] <= ps3_reg[a] + pd3_reg[a] + pc3_reg[a];
            end

            // round to nearest: floor((2|n| + d) / 2d)
            ctl_reg.zero <= z4_reg;
            dvs_reg      <= {den4_reg, 1'b0};
            for (int a = 0; a < AXES; a++) begin
                ctl_reg.neg[a] <= n4_reg[a][NUM_W-1];
                dd_reg[a] <= ((n4_reg[a][NUM_W-1] ? mag_t'(-n4_reg[a]) : mag_t'(n4_reg[a])) << 1)
                             + mag_t'(den4_reg);
            end
        end
    end

    assign ctl      = ctl_reg;
    assign dividend = dd_reg;
    assign divisor  = dvs_reg;

endmodule

[rtl/qvr_div.sv]
module qvr_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  qvr_pkg::div_ctl_t  ctl_in,
    input  qvr_pkg::mag3_t     dividend,
    input  qvr_pkg::dvs_t      divisor,
    output qvr_pkg::div_ctl_t  ctl_out,
    output qvr_pkg::quo3_t     quotient
);
    import qvr_pkg::*;

    // one restoring step per stage, MSB of the quotient first
    div_ctl_t ctl_reg [Q_W];
    mag3_t    rem_reg [Q_W];
    quo3_t    q_reg   [Q_W];
    dvs_t     dvs_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        div_ctl_t c_in;
        mag3_t    r_in;
        quo3_t    q_in;
        dvs_t     d_in;
        mag_t     sh;

        if (k == 0) begin : g_first
            assign c_in = ctl_in;
            assign r_in = dividend;
            assign q_in = '0;
            assign d_in = divisor;
        end else begin : g_rest
            assign c_in = ctl_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = dvs_reg[k-1];
        end

        assign sh = mag_t'(d_in) << (Q_W - 1 - k);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k].valid <= 1'b0;
            end else if (en) begin
                ctl_reg[k].valid <= c_in.valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctl_reg[k].zero <= c_in.zero;
                ctl_reg[k].neg  <= c_in.neg;
                dvs_reg[k]      <= d_in;
                for (int a = 0; a < AXES; a++) begin
                    if (r_in[a] >= sh) begin
                        rem_reg[k][a] <= r_in[a] - sh;
                        q_reg[k][a]   <= {q_in[a][Q_W-2:0], 1'b1};
                    end else begin
                        rem_reg[k][a] <= r_in[a];
                        q_reg[k][a]   <= {q_in[a][Q_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign ctl_out  = ctl_reg[Q_W-1];
    assign quotient = q_reg[Q_W-1];

endmodule

[rtl/quaternion_vector_rotate.sv]
// Channel  Dir  Handshake           Beat
// s_       in   s_valid / s_ready   s_vec_x/y/z, s_quat_w/bx/by/bz
// m_       out  m_valid / m_ready   m_rot_x/y/z, m_zero_quat_error
//
// One beat per cycle while the output is not held; 5 arithmetic stages, 17 divider
// steps one quotient bit each, 1 output register.
// Synchronous active-low reset clears every valid bit; data regs are not reset.
// A held output beat stalls the whole pipe and drops s_ready; bubbles are not
// squeezed out.
module quaternion_vector_rotate (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qvr_pkg::in_t         s_vec_x,
    input  qvr_pkg::in_t         s_vec_y,
    input  qvr_pkg::in_t         s_vec_z,
    input  qvr_pkg::in_t         s_quat_w,
    input  qvr_pkg::in_t         s_quat_bx,
    input  qvr_pkg::in_t         s_quat_by,
    input  qvr_pkg::in_t         s_quat_bz,
    output logic                 m_valid,
    input  logic                 m_ready,
    output qvr_pkg::out_t        m_rot_x,
    output qvr_pkg::out_t        m_rot_y,
    output qvr_pkg::out_t        m_rot_z,
    output logic                 m_zero_quat_error
);
    import qvr_pkg::*;

    logic     en;
    div_ctl_t f_ctl, d_ctl;
    mag3_t    f_dd;
    dvs_t     f_dvs;
    quo3_t    d_q;

    logic     m_valid_reg;
    logic     zero_reg;
    out_t     rot_reg [AXES];
    quo_t     qc [AXES];

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    qvr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .vec_x    (s_vec_x),
        .vec_y    (s_vec_y),
        .vec_z    (s_vec_z),
        .quat_w   (s_quat_w),
        .quat_bx  (s_quat_bx),
        .quat_by  (s_quat_by),
        .quat_bz  (s_quat_bz),
        .ctl      (f_ctl),
        .dividend (f_dd),
        .divisor  (f_dvs)
    );

    qvr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctl_in   (f_ctl),
        .dividend (f_dd),
        .divisor  (f_dvs),
        .ctl_out  (d_ctl),
        .quotient (d_q)
    );

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            qc[a] = (d_q[a] > quo_t'(OUT_LIMIT)) ? quo_t'(OUT_LIMIT) : d_q[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= d_ctl.zero;
            for (int a = 0; a < AXES; a++) begin
                if (d_ctl.zero) begin
                    rot_reg[a] <= '0;
                end else if (d_ctl.neg[a]) begin
                    rot_reg[a] <= -out_t'(qc[a]);
                end else begin
                    rot_reg[a] <= out_t'(qc[a]);
                end
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_zero_quat_error = zero_reg;
    assign m_rot_x           = rot_reg[0];
    assign m_rot_y           = rot_reg[1];
    assign m_rot_z           = rot_reg[2];

`ifndef SYNTHESIS
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_quat_error |-> m_rot_x == '0 && m_rot_y == '0 && m_rot_z == '0)
        else $error("zero quaternion beat carries non-zero result");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_rot_x <= out_t'(OUT_LIMIT) && m_rot_x >= -out_t'(OUT_LIMIT)
                 && m_rot_y <= out_t'(OUT_LIMIT) && m_rot_y >= -out_t'(OUT_LIMIT)
                 && m_rot_z <= out_t'(OUT_LIMIT) && m_rot_z >= -out_t'(OUT_LIMIT))
        else $error("result outside saturation range");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a blocked output");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(d_ctl) && $stable(f_ctl))
        else $error("pipeline moved during output stall");
`endif

endmodule

[tb/quaternion_vector_rotate_tb.sv]
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;
    import qvr_pkg::*;

    typedef struct {
        in_t vx, vy, vz, w, bx, by, bz;
    } rot_req_t;

    typedef struct {
        out_t x, y, z;
        logic zero;
    } rot_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_vec_x = '0, s_vec_y = '0, s_vec_z = '0;
    in_t  s_quat_w = '0, s_quat_bx = '0, s_quat_by = '0, s_quat_bz = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_rot_x, m_rot_y, m_rot_z;
    logic m_zero_quat_error;

    rot_res_t rotated_q[$];
    int   n_errors = 0;
    bit   sink_hold = 1'b0;
    bit   sink_hold_req = 1'b0;

    quaternion_vector_rotate dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint div_nearest(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic out_t clamp_axis(longint r);
        if (r > OUT_LIMIT) r = OUT_LIMIT;
        if (r < -OUT_LIMIT) r = -OUT_LIMIT;
        return out_t'(r);
    endfunction

    function automatic rot_res_t rotate_vec(rot_req_t t);
        rot_res_t r;
        longint vx, vy, vz, w, bx, by, bz, w2, b2, den, s, dot2, cx, cy, cz;
        vx = t.vx; vy = t.vy; vz = t.vz;
        w = t.w; bx = t.bx; by = t.by; bz = t.bz;
        w2 = w * w;
        b2 = bx * bx + by * by + bz * bz;
        den = w2 + b2;
        r.x = '0; r.y = '0; r.z = '0; r.zero = 1'b1;
        if (den != 0) begin
            s = w2 - b2;
            dot2 = 2 * (vx * bx + vy * by + vz * bz);
            cx = by * vz - bz * vy;
            cy = bz * vx - bx * vz;
            cz = bx * vy - by * vx;
            r.x = clamp_axis(div_nearest(vx * s + bx * dot2 + 2 * w * cx, den));
            r.y = clamp_axis(div_nearest(vy * s + by * dot2 + 2 * w * cy, den));
            r.z = clamp_axis(div_nearest(vz * s + bz * dot2 + 2 * w * cz, den));
            r.zero = 1'b0;
        end
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // one beat in; expectation queued at acceptance
    task automatic send_beat(rot_req_t t);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_vec_x   <= t.vx; s_vec_y <= t.vy; s_vec_z <= t.vz;
        s_quat_w  <= t.w;  s_quat_bx <= t.bx;
        s_quat_by <= t.by; s_quat_bz <= t.bz;
        do @(posedge aclk); while (!s_ready);
        rotated_q.push_back(rotate_vec(t));
    endtask

    function automatic in_t rnd16();
        case ($urandom_range(0, 5))
            0: return in_t'(16'h8000);
            1: return in_t'(16'h7fff);
            2: return in_t'(int'($urandom_range(0, 15)) - 8);
            default: return in_t'($urandom());
        endcase
    endfunction

    function automatic rot_req_t rnd_req();
        rot_req_t t;
        t.vx = rnd16(); t.vy = rnd16(); t.vz = rnd16();
        t.w = rnd16(); t.bx = rnd16(); t.by = rnd16(); t.bz = rnd16();
        if ($urandom_range(0, 3) == 0) begin
            // quaternion components drawn from -16384..16383
            t.w  = in_t'(int'($urandom_range(0, 32767)) - 16384);
            t.bx = in_t'(int'($urandom_range(0, 32767)) - 16384);
            t.by = in_t'(int'($urandom_range(0, 32767)) - 16384);
            t.bz = in_t'(int'($urandom_range(0, 32767)) - 16384);
        end
        if ($urandom_range(0, 40) == 0) begin
            t.w = '0; t.bx = '0; t.by = '0; t.bz = '0;
        end
        return t;
    endfunction

    task automatic drain_wait();
        s_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        rot_req_t t;
        in_t ex[4];
        ex = '{in_t'(16'h8000), in_t'(16'h7fff), in_t'(0), in_t'(16384)};
        // identity, zero quaternion, pure axes, a mixed case, then extreme values
        t = '{16'sd256, -16'sd512, 16'sd1000, 16'sd16384, 0, 0, 0}; send_beat(t);
        t = '{16'sh7fff, 16'sh8000, 16'sd5, 0, 0, 0, 0}; send_beat(t);
        t = '{16'sd256, 0, 0, 0, 0, 0, 16'sd16384}; send_beat(t);
        t = '{0, 16'sd256, 0, 0, 16'sd16384, 0, 0}; send_beat(t);
        t = '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd0}; send_beat(t);
        t = '{16'sd3, 0, 0, 16'sd1, 16'sd1, 0, 0}; send_beat(t); // vector on the rotation axis
        for (int i = 0; i < 4; i++) begin
            t = '{ex[i], ex[i], ex[i], ex[i], ex[(i+1)%4], ex[i], ex[(i+3)%4]};
            send_beat(t);
            t = '{ex[i], ex[3-i], ex[i], ex[3-i], ex[3-i], ex[3-i], ex[3-i]};
            send_beat(t);
        end
        t = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_beat(t);
        t = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_beat(t);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_beat(rnd_req());
    endtask

    task automatic test_backpressure();
        sink_hold_req = 1'b1;
        test_random(60);
        sink_hold_req = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        test_random(30);
        drain_wait();
        test_random(30);
    endtask

    // receiver: random stalls, plus a long hold when requested
    initial begin
        int g;
        forever begin
            @(posedge aclk);
            if (sink_hold_req && !sink_hold) begin
                sink_hold = 1'b1;
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                sink_hold = 1'b0;
            end
            g = gap_len();
            m_ready <= (g == 0);
        end
    end

    always @(posedge aclk) begin
        rot_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (rotated_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
            end else begin
                e = rotated_q.pop_front();
                if (m_rot_x !== e.x) begin
                    $error("rot_x exp %0d got %0d", e.x, m_rot_x); n_errors++;
                end
                if (m_rot_y !== e.y) begin
                    $error("rot_y exp %0d got %0d", e.y, m_rot_y); n_errors++;
                end
                if (m_rot_z !== e.z) begin
                    $error("rot_z exp %0d got %0d", e.z, m_rot_z); n_errors++;
                end
                if (m_zero_quat_error !== e.zero) begin
                    $error("zero_quat_error exp %0b got %0b", e.zero, m_zero_quat_error);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_pause_until_drained();
        test_random(520);
        drain_wait();
        repeat (60) @(posedge aclk);
        if (n_errors == 0 && rotated_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
